// ----- rtl/hhve_pkg.sv -----
`default_nettype none
package hhve_pkg;

  localparam int MAX_NAME_LEN_DEF = 16;
  localparam int QUEUE_DEPTH_DEF  = 4;
  localparam int NAME_BYTES       = 16;

  localparam logic [4:0] COUNT_MAX = 5'd31;

  localparam logic [1:0] REG_NAME_LOW  = 2'd0;
  localparam logic [1:0] REG_NAME_HIGH = 2'd1;
  localparam logic [1:0] REG_NAME_LEN  = 2'd2;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  localparam logic [1:0] TYPE_UNKNOWN = 2'd0;

  localparam logic [8*5-1:0] PFX_HTTP    = "HTTP/";
  localparam logic [8*7-1:0] PFX_NOTIFY  = "NOTIFY ";
  localparam logic [8*9-1:0] PFX_MSEARCH = "M-SEARCH ";

  typedef enum logic [2:0] {
    PH_FIRST = 3'd0,
    PH_KEY   = 3'd1,
    PH_SKIP  = 3'd2,
    PH_LEAD  = 3'd3,
    PH_BODY  = 3'd4,
    PH_DONE  = 3'd5
  } phase_t;

  // one request's worth of results, emitted cr, byt, sum in that order
  typedef struct packed {
    logic       cr;
    logic       byt;
    logic       sum;
    logic [7:0] val;
    logic [1:0] ptype;
    logic       found;
  } bundle_t;

  function automatic logic [7:0] fold(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= 8'h61 && b <= 8'h7A) r = b - 8'd32;
    return r;
  endfunction

  function automatic logic [4:0] pfx_len(input logic [1:0] k);
    logic [4:0] r;
    case (k)
      2'd0:    r = 5'd5;
      2'd1:    r = 5'd7;
      2'd2:    r = 5'd9;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] pfx_char(input logic [1:0] k, input logic [4:0] i);
    logic [7:0] r;
    int         j;
    r = 8'h00;
    j = int'(pfx_len(k)) - 1 - int'(i);
    if (j >= 0) begin
      case (k)
        2'd0:    r = PFX_HTTP[8*j +: 8];
        2'd1:    r = PFX_NOTIFY[8*j +: 8];
        2'd2:    r = PFX_MSEARCH[8*j +: 8];
        default: r = 8'h00;
      endcase
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/hhve_front.sv -----
`default_nettype none
module hhve_front import hhve_pkg::*; #(
  parameter int MAX_NAME_LEN = MAX_NAME_LEN_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        accept,
  input  wire logic [7:0]  data_byte,
  input  wire logic        eop,
  output bundle_t          bundle,
  output logic             push
);

  logic [8*NAME_BYTES-1:0] name_r;
  logic [4:0]              name_len_r;

  phase_t     phase_r, phase_step, phase_nxt;
  logic [4:0] cnt_r, cnt_step, cnt_nxt;
  logic       km_r, km_step, km_nxt;
  logic [2:0] cand_r, cand_step, cand_nxt;
  logic [1:0] type_r, type_step, type_nxt;
  logic       found_r, found_step, found_nxt;
  logic       held_r, held_step, held_nxt;

  logic [4:0] eff_len;
  logic [4:0] cnt_inc;
  logic [7:0] name_ch;
  logic       cr_emit, byte_emit;

  assign eff_len = (name_len_r > 5'(MAX_NAME_LEN)) ? 5'(MAX_NAME_LEN) : name_len_r;
  assign cnt_inc = (cnt_r < COUNT_MAX) ? cnt_r + 5'd1 : cnt_r;
  assign name_ch = name_r[8*cnt_r[3:0] +: 8];

  // next state
  always_comb begin
    phase_step = phase_r;
    cnt_step   = cnt_r;
    km_step    = km_r;
    cand_step  = cand_r;
    type_step  = type_r;
    found_step = found_r;
    held_step  = held_r;
    case (phase_r)
      PH_FIRST: begin
        if (data_byte == CH_LF) begin
          phase_step = PH_KEY;
          cnt_step   = 5'd0;
          km_step    = 1'b1;
          held_step  = 1'b0;
        end else begin
          for (int k = 0; k < 3; k++) begin
            if (cand_r[k]) begin
              if (cnt_r >= pfx_len(2'(k)) || fold(data_byte) != pfx_char(2'(k), cnt_r)) begin
                cand_step[k] = 1'b0;
              end else if (cnt_r == pfx_len(2'(k)) - 5'd1) begin
                type_step = 2'(k + 1);
                cand_step = 3'b000;
              end
            end
          end
          cnt_step = cnt_inc;
        end
      end
      PH_KEY: begin
        if (data_byte == CH_LF) begin
          if (cnt_r == 5'd0 || (cnt_r == 5'd1 && held_r)) begin
            phase_step = PH_DONE;
          end else begin
            phase_step = PH_KEY;
            cnt_step   = 5'd0;
            km_step    = 1'b1;
            held_step  = 1'b0;
          end
        end else if (data_byte == CH_COLON) begin
          held_step = 1'b0;
          if (km_r && cnt_r == eff_len) begin
            found_step = 1'b1;
            phase_step = PH_LEAD;
          end else begin
            phase_step = PH_SKIP;
          end
        end else begin
          if (cnt_r >= eff_len || fold(data_byte) != fold(name_ch)) km_step = 1'b0;
          held_step = (data_byte == CH_CR);
          cnt_step  = cnt_inc;
        end
      end
      PH_SKIP: begin
        if (data_byte == CH_LF) begin
          phase_step = PH_KEY;
          cnt_step   = 5'd0;
          km_step    = 1'b1;
          held_step  = 1'b0;
        end
      end
      PH_LEAD: begin
        if (data_byte == CH_SP || data_byte == CH_TAB) begin
          phase_step = PH_LEAD;
        end else if (data_byte == CH_LF) begin
          phase_step = PH_DONE;
        end else begin
          held_step  = (data_byte == CH_CR);
          phase_step = PH_BODY;
        end
      end
      PH_BODY: begin
        if (data_byte == CH_LF) begin
          phase_step = PH_DONE;
          held_step  = 1'b0;
        end else begin
          held_step = (data_byte == CH_CR);
        end
      end
      default: ;
    endcase

    if (eop) begin
      phase_nxt = PH_FIRST;
      cnt_nxt   = 5'd0;
      km_nxt    = 1'b1;
      cand_nxt  = 3'b111;
      type_nxt  = TYPE_UNKNOWN;
      found_nxt = 1'b0;
      held_nxt  = 1'b0;
    end else begin
      phase_nxt = phase_step;
      cnt_nxt   = cnt_step;
      km_nxt    = km_step;
      cand_nxt  = cand_step;
      type_nxt  = type_step;
      found_nxt = found_step;
      held_nxt  = held_step;
    end
  end

  // outputs
  always_comb begin
    cr_emit   = (phase_r == PH_BODY) && held_r && (data_byte != CH_LF);
    byte_emit = ((phase_r == PH_LEAD) && data_byte != CH_SP && data_byte != CH_TAB &&
                 data_byte != CH_LF && data_byte != CH_CR) ||
                ((phase_r == PH_BODY) && data_byte != CH_LF && data_byte != CH_CR);
    bundle.cr    = cr_emit;
    bundle.byt   = byte_emit;
    bundle.sum   = eop;
    bundle.val   = data_byte;
    bundle.ptype = type_step;
    bundle.found = found_step;
    push         = accept && (cr_emit || byte_emit || eop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_FIRST;
      cnt_r      <= 5'd0;
      km_r       <= 1'b1;
      cand_r     <= 3'b111;
      type_r     <= TYPE_UNKNOWN;
      found_r    <= 1'b0;
      held_r     <= 1'b0;
      name_r     <= '0;
      name_len_r <= 5'd0;
    end else begin
      if (accept) begin
        phase_r <= phase_nxt;
        cnt_r   <= cnt_nxt;
        km_r    <= km_nxt;
        cand_r  <= cand_nxt;
        type_r  <= type_nxt;
        found_r <= found_nxt;
        held_r  <= held_nxt;
      end
      if (cfg_valid) begin
        case (cfg_index)
          REG_NAME_LOW:  name_r[63:0]   <= cfg_data;
          REG_NAME_HIGH: name_r[127:64] <= cfg_data;
          REG_NAME_LEN:  name_len_r     <= cfg_data[4:0];
          default: ;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/hhve_queue.sv -----
`default_nettype none
module hhve_queue import hhve_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire bundle_t push_data,
  output logic         full,
  input  wire logic    pop,
  output logic         not_empty,
  output bundle_t      head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  bundle_t         mem_r [DEPTH];
  logic [AW-1:0]   wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_nxt    = wr_r;
    rd_nxt    = rd_r;
    count_nxt = count_r;
    if (do_push) wr_nxt = (wr_r == AW'(DEPTH - 1)) ? '0 : wr_r + AW'(1);
    if (do_pop)  rd_nxt = (rd_r == AW'(DEPTH - 1)) ? '0 : rd_r + AW'(1);
    if (do_push && !do_pop)      count_nxt = count_r + CW'(1);
    else if (!do_push && do_pop) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= push_data;
  end

endmodule
`default_nettype wire

// ----- rtl/hhve_back.sv -----
`default_nettype none
module hhve_back import hhve_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  input  wire bundle_t     q_head,
  output logic             q_pop,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,
  output logic             out_tuser,
  output logic             out_tlast
);

  bundle_t    cur_r, cur_nxt;
  logic [2:0] mask_r, mask_nxt, mask_left;
  logic       fire;
  logic [7:0] val;
  logic [1:0] ptype;
  logic       found, kind;

  assign out_tvalid = (mask_r != 3'b000);
  assign fire       = out_tvalid && out_tready;

  always_comb begin
    kind  = 1'b0;
    val   = 8'h00;
    ptype = 2'd0;
    found = 1'b0;
    mask_left = mask_r;
    if (mask_r[2]) begin
      val = CH_CR;
      mask_left[2] = 1'b0;
    end else if (mask_r[1]) begin
      val = cur_r.val;
      mask_left[1] = 1'b0;
    end else if (mask_r[0]) begin
      kind  = 1'b1;
      ptype = cur_r.ptype;
      found = cur_r.found;
      mask_left[0] = 1'b0;
    end
    out_tdata = {5'b0, found, ptype, val};
    out_tuser = kind;
    out_tlast = (mask_left == 3'b000);

    if (!fire) mask_left = mask_r;
    q_pop    = (mask_left == 3'b000) && q_valid;
    cur_nxt  = q_pop ? q_head : cur_r;
    mask_nxt = q_pop ? {q_head.cr, q_head.byt, q_head.sum} : mask_left;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) mask_r <= 3'b000;
    else        mask_r <= mask_nxt;
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

endmodule
`default_nettype wire

// ----- rtl/http_header_value_extractor.sv -----
`default_nettype none
// Streams the value of one configured header out of HTTP/SSDP packet text, one byte per
// input request, and closes each packet with a summary (packet type and found flag).
// An input byte is taken every cycle as long as the result queue has room; one byte
// causes up to three results (a held CR, the value byte, the summary), and the output
// side drains them at one per cycle while out_tready is high, so the sustained rate is
// one byte per cycle while bytes yield at most one result each and out_tready stays
// high. The QUEUE_DEPTH-entry result queue between the parser and the output serializer
// sets how long either side may stall before the other one waits.
module http_header_value_extractor import hhve_pkg::*; #(
  parameter int MAX_NAME_LEN = MAX_NAME_LEN_DEF,
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // data_byte
  input  wire logic        in_tlast,   // end_of_packet
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // value_byte[7:0], packet_type[9:8], header_found[10]
  output logic             out_tuser,  // result_kind
  output logic             out_tlast,  // last_of_run
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  bundle_t bundle, head;
  logic    push, full, pop, not_empty, accept;

  assign cfg_ready = 1'b1;
  assign in_tready = !full;
  assign accept    = in_tvalid && in_tready;

  hhve_front #(.MAX_NAME_LEN(MAX_NAME_LEN)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .data_byte (in_tdata),
    .eop       (in_tlast),
    .bundle    (bundle),
    .push      (push)
  );

  hhve_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (bundle),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  hhve_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (not_empty),
    .q_head     (head),
    .q_pop      (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire
